FILE: sv/parallel_io_port_pair_defines.svh
// Assertion macros shared by the parallel I/O port pair RTL.
`ifndef PARALLEL_IO_PORT_PAIR_DEFINES_SVH
`define PARALLEL_IO_PORT_PAIR_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted.
`define PIO_ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("parallel_io_port_pair: check failed");

// Clocked check that also holds during reset.
`define PIO_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("parallel_io_port_pair: check failed");

`else

`define PIO_ASSERT_RST(label, clk, rst_n, prop)
`define PIO_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: sv/pio_pkg.sv
// Types and constants of the parallel I/O port pair.
`timescale 1ns / 1ps

package pio_pkg;

	// Port operating modes.
	typedef enum logic [1:0] {
		MODE_OUTPUT = 2'd0,
		MODE_INPUT  = 2'd1,
		MODE_BIDIR  = 2'd2,
		MODE_BITCTL = 2'd3
	} mode_t;

	// Control word expected next on a port.
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_DIR  = 2'd1,
		PEND_MASK = 2'd2
	} pend_t;

	// Bus access kinds.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Low-nibble codes of control words.
	localparam logic [3:0] CW_MODE = 4'hf;
	localparam logic [3:0] CW_ICTL = 4'h7;
	localparam logic [3:0] CW_IEN  = 4'h3;

	// Bit positions inside control words.
	localparam int ICTL_MASK_FOLLOWS = 4;
	localparam int IEN_BIT           = 7;

	// Reset values.
	localparam logic [7:0] DIR_RESET = 8'hff;

endpackage

FILE: sv/parallel_io_port_pair.sv
// A transaction passes the input stage and then the result register.
// Throughput: one transaction per cycle unless the result register stalls; the port
// register update is decode logic between the input stage and the result register.
// Reset: arst_n clears both ports to input mode, all-input direction mask, zero
// latches and interrupt words, nothing pending, and empties the pipeline.
`timescale 1ns / 1ps
`include "parallel_io_port_pair_defines.svh"

module parallel_io_port_pair (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [1:0] reg_offset,
	input  logic [7:0] write_data,
	input  logic [7:0] pin_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       drive_valid,
	output logic       drive_port,
	output logic [7:0] drive_data
);

	// Input stage.
	logic       valid_s1;
	logic       opcode_s1;
	logic [1:0] reg_offset_s1;
	logic [7:0] write_data_s1;
	logic [7:0] pin_level_s1;

	// Per-port state.
	pio_pkg::mode_t mode_q [2];
	pio_pkg::pend_t pend_q [2];
	logic [7:0]     latch_q [2];
	logic [7:0]     dir_q [2];
	logic [7:0]     ictl_q [2];
	logic [7:0]     imask_q [2];
	logic [7:0]     ivec_q [2];

	pio_pkg::mode_t mode_d [2];
	pio_pkg::pend_t pend_d [2];
	logic [7:0]     latch_d [2];
	logic [7:0]     dir_d [2];
	logic [7:0]     ictl_d [2];
	logic [7:0]     imask_d [2];
	logic [7:0]     ivec_d [2];

	// Result register.
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       drive_valid_q;
	logic       drive_port_q;
	logic [7:0] drive_data_q;

	logic           advance;
	logic           port_sel;
	logic           is_ctl;
	logic           is_wr;
	logic [7:0]     rd_val;
	logic           drv_val;
	pio_pkg::mode_t new_mode;

	// The input stage moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign port_sel = reg_offset_s1[1];
	assign is_ctl   = reg_offset_s1[0];
	assign is_wr    = (opcode_s1 == pio_pkg::OP_WRITE);

	// Requested mode; port B cannot run bidirectional and falls back to bit control.
	always_comb begin
		new_mode = pio_pkg::mode_t'(write_data_s1[7:6]);
		if (new_mode == pio_pkg::MODE_BIDIR && port_sel)
			new_mode = pio_pkg::MODE_BITCTL;
	end

	// Read data path.
	always_comb begin
		rd_val = '0;
		if (!is_wr) begin
			if (is_ctl) begin
				rd_val = {ictl_q[0][7:6], 2'b00, ictl_q[1][7:4]};
			end else begin
				case (mode_q[port_sel])
					pio_pkg::MODE_OUTPUT: rd_val = latch_q[port_sel];
					pio_pkg::MODE_INPUT,
					pio_pkg::MODE_BIDIR:  rd_val = pin_level_s1;
					pio_pkg::MODE_BITCTL: begin
						rd_val = (pin_level_s1 & dir_q[port_sel]) |
							(latch_q[port_sel] & ~dir_q[port_sel]);
					end
					default:              rd_val = pin_level_s1;
				endcase
			end
		end
	end

	// A data write drives the pins unless the port is in input mode.
	assign drv_val = is_wr && !is_ctl && (mode_q[port_sel] != pio_pkg::MODE_INPUT);

	// Next-state decode for data and control writes.
	always_comb begin
		mode_d  = mode_q;
		pend_d  = pend_q;
		latch_d = latch_q;
		dir_d   = dir_q;
		ictl_d  = ictl_q;
		imask_d = imask_q;
		ivec_d  = ivec_q;
		if (is_wr && !is_ctl) begin
			latch_d[port_sel] = write_data_s1;
		end else if (is_wr && is_ctl) begin
			case (pend_q[port_sel])
				pio_pkg::PEND_DIR: begin
					dir_d[port_sel]  = write_data_s1;
					pend_d[port_sel] = pio_pkg::PEND_NONE;
				end
				pio_pkg::PEND_MASK: begin
					imask_d[port_sel] = write_data_s1;
					pend_d[port_sel]  = pio_pkg::PEND_NONE;
				end
				default: begin
					pend_d[port_sel] = pio_pkg::PEND_NONE;
					if (!write_data_s1[0]) begin
						ivec_d[port_sel] = write_data_s1;
					end else begin
						case (write_data_s1[3:0])
							pio_pkg::CW_MODE: begin
								mode_d[port_sel] = new_mode;
								if (new_mode == pio_pkg::MODE_BITCTL)
									pend_d[port_sel] = pio_pkg::PEND_DIR;
							end
							pio_pkg::CW_ICTL: begin
								ictl_d[port_sel] = write_data_s1;
								if (write_data_s1[pio_pkg::ICTL_MASK_FOLLOWS])
									pend_d[port_sel] = pio_pkg::PEND_MASK;
							end
							pio_pkg::CW_IEN: begin
								ictl_d[port_sel][pio_pkg::IEN_BIT] =
									write_data_s1[pio_pkg::IEN_BIT];
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1     <= opcode;
			reg_offset_s1 <= reg_offset;
			write_data_s1 <= write_data;
			pin_level_s1  <= pin_level;
		end
	end

	// Port state, updated as each transaction leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				mode_q[i]  <= pio_pkg::MODE_INPUT;
				pend_q[i]  <= pio_pkg::PEND_NONE;
				latch_q[i] <= '0;
				dir_q[i]   <= pio_pkg::DIR_RESET;
				ictl_q[i]  <= '0;
				imask_q[i] <= '0;
				ivec_q[i]  <= '0;
			end
		end else if (advance) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			latch_q <= latch_d;
			dir_q   <= dir_d;
			ictl_q  <= ictl_d;
			imask_q <= imask_d;
			ivec_q  <= ivec_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q   <= rd_val;
			drive_valid_q <= drv_val;
			drive_port_q  <= drv_val & port_sel;
			drive_data_q  <= drv_val ? write_data_s1 : 8'h00;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign drive_valid = drive_valid_q;
	assign drive_port  = drive_port_q;
	assign drive_data  = drive_data_q;

	// A stalled result register must hold the input stage.
	`PIO_ASSERT_RST(a_stall_blocks_input, clk, arst_n,
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
	// A driving transaction is a write and returns no read data.
	`PIO_ASSERT_RST(a_drive_no_read, clk, arst_n,
		(out_valid && drive_valid) |-> (read_data == 8'h00))
	// Without a drive the drive fields read as zero.
	`PIO_ASSERT_RST(a_idle_drive_zero, clk, arst_n,
		(out_valid && !drive_valid) |-> (drive_port == 1'b0 && drive_data == 8'h00))
	// Port B never enters bidirectional mode, even before the first reset edge.
	`PIO_ASSERT_ALWAYS(a_port_b_not_bidir, clk,
		mode_q[1] !== pio_pkg::MODE_BIDIR)

endmodule
